>>> design/rt_lpm_pkg.sv
// Package for the IPv6 route table: command and status codes, beat structs.
// No dependencies.
package rt_lpm_pkg;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_ROUTE  = 3'd2,
        CMD_GW     = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LIFETIME = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    localparam logic [31:0] NEVER_EXPIRES  = 32'hFFFF_FFFF;
    localparam logic [31:0] LIFETIME_RESET = 32'd1073741;

    typedef struct packed {
        logic [2:0]        command;
        logic [2:0]        iface;
        logic [63:0]       prefix_hi;
        logic [63:0]       prefix_lo;
        logic [7:0]        prefix_len;
        logic [63:0]       gateway_hi;
        logic [63:0]       gateway_lo;
        logic signed [7:0] preference;
        logic [31:0]       lifetime;
        logic [63:0]       dest_hi;
        logic [63:0]       dest_lo;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [2:0]  out_iface;
        logic [63:0] out_gateway_hi;
        logic [63:0] out_gateway_lo;
    } rsp_t;

    // True when the first floor(len/8) bytes (at most 16) of a and b agree.
    function automatic logic bytes_equal(input logic [127:0] a, input logic [127:0] b,
                                         input logic [7:0] len);
        logic [4:0]   n;
        logic [127:0] m;
        begin
            n = (len[7:3] > 5'd16) ? 5'd16 : len[7:3];
            m = ~({128{1'b1}} >> {n, 3'b000});
            bytes_equal = ((a ^ b) & m) == '0;
        end
    endfunction

endpackage

>>> design/ipv6_route_table_lpm.sv
// IPv6 longest-prefix route table. A lookup scans every entry; a remove or an add scans
// until the key matches or the entries end, then a remove shifts the later entries up and
// an add writes the entry. A tick scans every entry, and each expiry shifts the later
// entries up, one a cycle, before the scan goes on.
// Throughput: one command at a time; busy is high until the result beat is strobed.
// The result beat cannot be stalled. Reset empties the table and loads the default lifetime.
module ipv6_route_table_lpm
    import rt_lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int IFACE_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_WRITE = 6'b000100,
        S_SHIFT = 6'b001000,
        S_TICK  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Entry stores; one entry is visited each cycle.
    logic [2:0]        e_iface [TABLE_DEPTH];
    logic [127:0]      e_pfx   [TABLE_DEPTH];
    logic [7:0]        e_len   [TABLE_DEPTH];
    logic [127:0]      e_gw    [TABLE_DEPTH];
    logic signed [7:0] e_pref  [TABLE_DEPTH];
    logic [31:0]       e_rem   [TABLE_DEPTH];

    state_t      state_reg;
    req_t        req_reg;
    logic [31:0] maxlife_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic        found_reg;
    logic [IW-1:0] best_reg;
    logic        resume_tick_reg;
    rsp_t        rsp_reg;
    logic        done_reg;

    logic [IW-1:0] idx;
    logic [IW-1:0] nxt;
    logic          in_range;
    logic          key_hit;
    logic          route_hit;
    logic          better;
    logic          iface_bad;
    logic          life_bad;

    assign idx = idx_reg[IW-1:0];
    assign nxt = IW'(idx_reg + 1'b1);
    assign in_range = idx_reg < count_reg;
    assign iface_bad = 32'(req_reg.iface) >= IFACE_COUNT;
    assign life_bad = req_reg.lifetime > maxlife_reg && req_reg.lifetime != NEVER_EXPIRES;

    // Key and route comparisons on the entry under the scan pointer.
    always_comb
    begin
        key_hit = e_iface[idx] == req_reg.iface && e_len[idx] == req_reg.prefix_len &&
                  e_gw[idx] == {req_reg.gateway_hi, req_reg.gateway_lo} &&
                  bytes_equal(e_pfx[idx], {req_reg.prefix_hi, req_reg.prefix_lo}, e_len[idx]);
        route_hit = bytes_equal(e_pfx[idx], {req_reg.dest_hi, req_reg.dest_lo}, e_len[idx]) &&
                    (req_reg.command != CMD_GW || e_iface[idx] == req_reg.iface);
        better = !found_reg || e_len[idx] > e_len[best_reg] ||
                 (e_len[idx] == e_len[best_reg] && e_pref[idx] > e_pref[best_reg]);
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Entry stores: append, refresh, shift up and tick decrement.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            if (!found_reg)
            begin
                e_iface[idx] <= req_reg.iface;
                e_pfx[idx]   <= {req_reg.prefix_hi, req_reg.prefix_lo};
                e_len[idx]   <= req_reg.prefix_len;
                e_gw[idx]    <= {req_reg.gateway_hi, req_reg.gateway_lo};
                e_pref[idx]  <= req_reg.preference;
                e_rem[idx]   <= req_reg.lifetime;
            end
            else
            begin
                e_pref[best_reg] <= req_reg.preference;
                e_rem[best_reg]  <= req_reg.lifetime;
            end
        end
        else if (state_reg == S_SHIFT && CW'(idx_reg + 1'b1) < count_reg)
        begin
            e_iface[idx] <= e_iface[nxt];
            e_pfx[idx]   <= e_pfx[nxt];
            e_len[idx]   <= e_len[nxt];
            e_gw[idx]    <= e_gw[nxt];
            e_pref[idx]  <= e_pref[nxt];
            e_rem[idx]   <= e_rem[nxt];
        end
        else if (state_reg == S_TICK && in_range && e_rem[idx] > 32'd1 &&
                 e_rem[idx] != NEVER_EXPIRES)
        begin
            e_rem[idx] <= e_rem[idx] - 32'd1;
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            maxlife_reg     <= LIFETIME_RESET;
            count_reg       <= '0;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            best_reg        <= '0;
            resume_tick_reg <= 1'b0;
            done_reg        <= 1'b0;
            rsp_reg         <= '0;
            req_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                maxlife_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        rsp_reg   <= '0;
                        state_reg <= (req.command == CMD_TICK) ? S_TICK : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Early outs, then one entry per cycle.
                    if ((req_reg.command == CMD_ADD || req_reg.command == CMD_REMOVE ||
                         req_reg.command == CMD_GW) && iface_bad)
                    begin
                        rsp_reg.status <= ST_NOTFOUND;
                        state_reg <= S_DONE;
                    end
                    else if (req_reg.command == CMD_ADD && life_bad)
                    begin
                        rsp_reg.status <= ST_LIFETIME;
                        state_reg <= S_DONE;
                    end
                    else if (req_reg.command != CMD_ADD && req_reg.command != CMD_REMOVE &&
                             req_reg.command != CMD_ROUTE && req_reg.command != CMD_GW)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (in_range)
                    begin
                        if (req_reg.command == CMD_ADD || req_reg.command == CMD_REMOVE)
                        begin
                            if (key_hit)
                            begin
                                found_reg <= 1'b1;
                                best_reg  <= idx;
                                rsp_reg.slot <= 4'(idx);
                                rsp_reg.out_iface <= e_iface[idx];
                                {rsp_reg.out_gateway_hi, rsp_reg.out_gateway_lo} <= e_gw[idx];
                                state_reg <= (req_reg.command == CMD_ADD) ? S_WRITE : S_SHIFT;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            if (route_hit && better)
                            begin
                                found_reg <= 1'b1;
                                best_reg  <= idx;
                                rsp_reg.slot <= 4'(idx);
                                rsp_reg.out_iface <= e_iface[idx];
                                {rsp_reg.out_gateway_hi, rsp_reg.out_gateway_lo} <= e_gw[idx];
                            end
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else if (req_reg.command == CMD_ADD)
                    begin
                        if (32'(count_reg) >= TABLE_DEPTH)
                        begin
                            rsp_reg.status <= ST_FULL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            rsp_reg.slot <= 4'(idx_reg);
                            rsp_reg.out_iface <= req_reg.iface;
                            rsp_reg.out_gateway_hi <= req_reg.gateway_hi;
                            rsp_reg.out_gateway_lo <= req_reg.gateway_lo;
                            state_reg <= S_WRITE;
                        end
                    end
                    else
                    begin
                        // The result fields were cleared when the command was taken.
                        if (!found_reg)
                        begin
                            rsp_reg.status <= ST_NOTFOUND;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_WRITE:
                begin
                    if (!found_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_DONE;
                end
                S_SHIFT:
                begin
                    // Move later entries up by one, one a cycle.
                    if (CW'(idx_reg + 1'b1) < count_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        if (resume_tick_reg)
                        begin
                            resume_tick_reg <= 1'b0;
                            idx_reg   <= {{(CW-IW){1'b0}}, best_reg};
                            state_reg <= S_TICK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_TICK:
                begin
                    if (!in_range)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (e_rem[idx] != NEVER_EXPIRES && e_rem[idx] <= 32'd1)
                    begin
                        resume_tick_reg <= 1'b1;
                        best_reg  <= idx;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> test/route_table_checker.sv
// Checker for the IPv6 route table: keeps its own copy of the table, predicts each result beat
// from the accepted command beats and compares it field by field. Depends on rt_lpm_pkg.
module route_table_checker
    import rt_lpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  req_t        req,
    input  logic        done,
    input  rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending_count
);

    localparam int DEPTH  = 16;
    localparam int IFACES = 8;

    typedef struct {
        logic [2:0]        ifc;
        logic [127:0]      pfx;
        logic [7:0]        plen;
        logic [127:0]      gw;
        logic signed [7:0] pref;
        logic [31:0]       remaining;
    } route_t;

    route_t      routes[DEPTH];
    int          route_count;
    logic [31:0] lifetime_limit;
    rsp_t        expected_rsp[$];

    // True when the leading whole bytes of the prefix agree, sixteen bytes at most.
    function automatic bit prefix_agrees(logic [127:0] a, logic [127:0] b, logic [7:0] len);
        int           nbytes;
        logic [127:0] mask;
        begin
            nbytes = len / 8;
            if (nbytes > 16) nbytes = 16;
            mask = '0;
            for (int k = 0; k < nbytes * 8; k++) mask[127 - k] = 1'b1;
            return ((a ^ b) & mask) == '0;
        end
    endfunction

    function automatic rsp_t entry_rsp(int pos);
        rsp_t r;
        begin
            r = '0;
            r.slot = pos[3:0];
            r.out_iface = routes[pos].ifc;
            {r.out_gateway_hi, r.out_gateway_lo} = routes[pos].gw;
            return r;
        end
    endfunction

    function automatic void drop_route(int pos);
        for (int k = pos; k + 1 < route_count; k++) routes[k] = routes[k + 1];
        route_count--;
    endfunction

    // Works out the table update and the result beat for one command.
    function automatic rsp_t route_table_predict(req_t c);
        rsp_t         r;
        int           pos;
        logic [127:0] pfx, gw, dst;
        begin
            r = '0;
            pfx = {c.prefix_hi, c.prefix_lo};
            gw  = {c.gateway_hi, c.gateway_lo};
            dst = {c.dest_hi, c.dest_lo};
            if ((c.command == CMD_ADD || c.command == CMD_REMOVE || c.command == CMD_GW)
                && c.iface >= IFACES) begin
                r.status = ST_NOTFOUND;
                return r;
            end
            if (c.command == CMD_ADD || c.command == CMD_REMOVE) begin
                if (c.command == CMD_ADD && c.lifetime > lifetime_limit
                    && c.lifetime != NEVER_EXPIRES) begin
                    r.status = ST_LIFETIME;
                    return r;
                end
                pos = route_count;
                for (int k = 0; k < route_count; k++)
                    if (pos == route_count && routes[k].ifc == c.iface
                        && routes[k].plen == c.prefix_len && routes[k].gw == gw
                        && prefix_agrees(routes[k].pfx, pfx, routes[k].plen))
                        pos = k;
                if (c.command == CMD_REMOVE) begin
                    if (pos == route_count) begin
                        r.status = ST_NOTFOUND;
                        return r;
                    end
                    r = entry_rsp(pos);
                    drop_route(pos);
                    return r;
                end
                if (pos == route_count) begin
                    if (route_count >= DEPTH) begin
                        r.status = ST_FULL;
                        return r;
                    end
                    routes[pos].ifc = c.iface;
                    routes[pos].pfx = pfx;
                    routes[pos].plen = c.prefix_len;
                    routes[pos].gw = gw;
                    route_count++;
                end
                routes[pos].pref = c.preference;
                routes[pos].remaining = c.lifetime;
                return entry_rsp(pos);
            end
            if (c.command == CMD_ROUTE || c.command == CMD_GW) begin
                pos = route_count;
                for (int k = 0; k < route_count; k++) begin
                    if (c.command == CMD_GW && routes[k].ifc != c.iface) continue;
                    if (!prefix_agrees(routes[k].pfx, dst, routes[k].plen)) continue;
                    if (pos == route_count || routes[k].plen > routes[pos].plen
                        || (routes[k].plen == routes[pos].plen
                            && routes[k].pref > routes[pos].pref))
                        pos = k;
                end
                if (pos == route_count) r.status = ST_NOTFOUND;
                else r = entry_rsp(pos);
                return r;
            end
            if (c.command == CMD_TICK) begin
                pos = 0;
                while (pos < route_count) begin
                    if (routes[pos].remaining == NEVER_EXPIRES) pos++;
                    else if (routes[pos].remaining <= 1) drop_route(pos);
                    else begin
                        routes[pos].remaining--;
                        pos++;
                    end
                end
            end
            return r;
        end
    endfunction

    assign pending_count = expected_rsp.size();

    // Predict on each accepted command beat and compare each result beat.
    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            route_count = 0;
            lifetime_limit = LIFETIME_RESET;
            expected_rsp.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) lifetime_limit = cfg_wdata;
            if (done) begin
                if (expected_rsp.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %h", rsp);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.slot !== want.slot
                        || rsp.out_iface !== want.out_iface
                        || rsp.out_gateway_hi !== want.out_gateway_hi
                        || rsp.out_gateway_lo !== want.out_gateway_lo) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %h, got %h", want, rsp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) expected_rsp.push_back(route_table_predict(req));
        end
    end

endmodule

>>> test/tb_top.sv
// Testbench top for the IPv6 route table: drives command beats and lifetime settings, and
// gives the verdict. Depends on rt_lpm_pkg, ipv6_route_table_lpm and route_table_checker.
module tb_top;
    import rt_lpm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        done;
    rsp_t        rsp;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending_count;
    int          cycle_count;

    // Small pools of prefixes and gateways so that keys and lookups collide often.
    logic [127:0] prefix_pool[4];
    logic [127:0] gateway_pool[3];

    ipv6_route_table_lpm u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    route_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .done          (done),
        .rsp           (rsp),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle limit against a hung block.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random gap before a beat: mostly none or short, now and then long.
    task automatic idle_gap();
        int n;
        begin
            n = $urandom_range(0, 99);
            if (n < 50) n = 0;
            else if (n < 92) n = $urandom_range(1, 3);
            else n = $urandom_range(10, 40);
            repeat (n) @(posedge clk);
        end
    endtask

    // Presents one command beat and holds it until the block has taken it and is no longer
    // busy, then drops the beat.
    task automatic send_cmd(req_t c);
        begin
            idle_gap();
            start <= 1'b1;
            req <= c;
            @(posedge clk);
            while (busy) @(posedge clk);
            start <= 1'b0;
            req <= '0;
            @(posedge clk);
        end
    endtask

    // Builds a command whose keys and destinations come mostly from the pools.
    function automatic req_t make_cmd(logic [2:0] op);
        req_t         c;
        logic [127:0] p;
        int           sel;
        begin
            c = '0;
            c.command = op;
            c.iface = $urandom_range(0, 99) < 97 ? 3'($urandom_range(0, 2)) : 3'($urandom);
            p = prefix_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) == 0) p = {rand64(), rand64()};
            {c.prefix_hi, c.prefix_lo} = p;
            sel = $urandom_range(0, 19);
            if (sel < 17) c.prefix_len = 8'(8 * $urandom_range(0, 16) + $urandom_range(0, 1));
            else c.prefix_len = 8'($urandom);
            {c.gateway_hi, c.gateway_lo} = $urandom_range(0, 9) == 0 ? {rand64(), rand64()}
                                           : gateway_pool[$urandom_range(0, 2)];
            c.preference = 8'($urandom);
            sel = $urandom_range(0, 9);
            if (sel < 5) c.lifetime = $urandom_range(0, 6);
            else if (sel < 8) c.lifetime = NEVER_EXPIRES;
            else c.lifetime = $urandom;
            p = prefix_pool[$urandom_range(0, 3)];
            for (int k = 0; k < 128; k++) if ($urandom_range(0, 15) == 0) p[k] = ~p[k];
            if ($urandom_range(0, 7) == 0) p = {rand64(), rand64()};
            {c.dest_hi, c.dest_lo} = p;
            return c;
        end
    endfunction

    // Waits for every expected beat, plus time for a tick still at work.
    task automatic drain();
        begin
            while (pending_count != 0) @(posedge clk);
            repeat (40) @(posedge clk);
        end
    endtask

    task automatic write_limit(logic [31:0] v);
        begin
            drain();
            cfg_we <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    initial
    begin
        req_t         c;
        int           roll;
        logic [31:0]  limits[4];
        logic [479:0] noise;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        cycle_count = 0;
        prefix_pool[0] = 128'h2001_0db8_0000_0000_0000_0000_0000_0001;
        prefix_pool[1] = 128'h2001_0db8_00ff_0000_0000_0000_0000_0000;
        prefix_pool[2] = 128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff;
        prefix_pool[3] = 128'h0;
        gateway_pool[0] = 128'hfe80_0000_0000_0000_0000_0000_0000_0001;
        gateway_pool[1] = 128'h0;
        gateway_pool[2] = {2{64'hdead_beef_0123_4567}};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default lifetime limit, all commands, extremes of each field.
        c = make_cmd(CMD_ADD);
        c.prefix_len = 8'd128; c.lifetime = LIFETIME_RESET; c.preference = 8'sd127;
        send_cmd(c);
        c.lifetime = LIFETIME_RESET + 1; send_cmd(c);
        c.lifetime = NEVER_EXPIRES; c.preference = -8'sd128; send_cmd(c);
        c.prefix_len = 8'd255; c.iface = 3'd7; send_cmd(c);
        c.command = CMD_GW; send_cmd(c);
        c.prefix_len = 8'd0; c.iface = 3'd0; c.command = CMD_ADD;
        c.gateway_hi = '1; c.gateway_lo = '1; c.lifetime = 0; send_cmd(c);
        c.command = CMD_ROUTE; c.dest_hi = '1; c.dest_lo = '1; send_cmd(c);
        c.command = CMD_GW; send_cmd(c);
        c.command = CMD_TICK; send_cmd(c);
        c.command = CMD_ROUTE; send_cmd(c);
        c.command = 3'd5; send_cmd(c);
        c.command = 3'd7; send_cmd(c);
        // Fill past the table depth.
        for (int k = 0; k < 17; k++)
        begin
            c = make_cmd(CMD_ADD);
            c.iface = 3'd1; c.prefix_len = 8'd64; c.lifetime = NEVER_EXPIRES;
            c.gateway_lo = 64'(k);
            send_cmd(c);
        end
        c.command = CMD_REMOVE; c.gateway_lo = 64'd3; send_cmd(c);
        send_cmd(c);

        // Random phases under several lifetime limits, extremes included.
        limits[0] = 32'd0; limits[1] = 32'hFFFF_FFFF; limits[2] = 32'd3; limits[3] = 32'hFFFF_FFFE;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(ph == 4 ? $urandom : limits[ph]);
            for (int k = 0; k < 220; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40) c = make_cmd(CMD_ADD);
                else if (roll < 55) c = make_cmd(CMD_REMOVE);
                else if (roll < 72) c = make_cmd(CMD_ROUTE);
                else if (roll < 86) c = make_cmd(CMD_GW);
                else if (roll < 98) c = make_cmd(CMD_TICK);
                else c = make_cmd(3'($urandom_range(5, 7)));
                if ($urandom_range(0, 19) == 0)
                begin
                    noise = {$urandom, rand64(), rand64(), rand64(),
                             rand64(), rand64(), rand64(), rand64()};
                    c = noise[$bits(req_t)-1:0];
                end
                send_cmd(c);
            end
        end

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
design/rt_lpm_pkg.sv
design/ipv6_route_table_lpm.sv
test/route_table_checker.sv
test/tb_top.sv
